@@ hw/rtl/qsct_pkg.sv @@
// Package for the query string command tokenizer.
// Holds the byte classes, the queue entry type and the default sizes.
// Depends on nothing; every module of the block imports it.
package qsct_pkg;

  localparam int DefMaxTokens = 32;
  localparam int DefQueueDepth = 4;
  localparam int TokenNumW = 5;

  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_QMARK,
    CLS_EQ,
    CLS_AMP,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic       last;
  } qsct_item_t;

endpackage

@@ hw/rtl/qsct_front.sv @@
// Front end of the tokenizer: classifies each incoming byte.
// Produces a queue entry with the byte, its class and the end flag.
// Depends on qsct_pkg.
module qsct_front
  import qsct_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output qsct_item_t item_o
);

  cls_e cls;

  always_comb begin
    if (data_byte_i == 8'h00) begin
      cls = CLS_NUL;
    end else if (data_byte_i == ChQmark) begin
      cls = CLS_QMARK;
    end else if (data_byte_i == ChEq) begin
      cls = CLS_EQ;
    end else if (data_byte_i == ChAmp) begin
      cls = CLS_AMP;
    end else if (data_byte_i >= ChZero && data_byte_i <= ChNine) begin
      cls = CLS_DIGIT;
    end else if (data_byte_i == ChSpace ||
                 (data_byte_i >= ChTab && data_byte_i <= ChCr)) begin
      cls = CLS_SPACE;
    end else if (data_byte_i == ChPlus) begin
      cls = CLS_PLUS;
    end else if (data_byte_i == ChMinus) begin
      cls = CLS_MINUS;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign item_o.data = data_byte_i;
  assign item_o.cls  = cls;
  assign item_o.last = last_byte_i;

endmodule

@@ hw/rtl/qsct_fifo.sv @@
// Short queue between the byte classifier and the token parser.
// Register storage with read and write pointers and an entry count.
// Depends on qsct_pkg for the entry type.
module qsct_fifo
  import qsct_pkg::*;
#(
  parameter int DEPTH = DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qsct_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output qsct_item_t pop_item_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qsct_item_t       mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ hw/rtl/qsct_back.sv @@
// Back end of the tokenizer: parse state machine, index and value
// converters, and the output register that holds one result.
// Depends on qsct_pkg for the byte classes and the queue entry type.
module qsct_back
  import qsct_pkg::*;
#(
  parameter int MAX_TOKENS = DefMaxTokens
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  qsct_item_t            item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  token_valid_o,
  output logic [7:0]            cmd_letter_o,
  output logic signed [31:0]    cmd_index_o,
  output logic [31:0]           cmd_value_o,
  output logic                  string_done_o,
  output logic [TokenNumW-1:0]  token_number_o
);

  localparam int CntW = $clog2(MAX_TOKENS + 1);

  localparam logic [2:0] PH_WAIT_Q    = 3'd0;
  localparam logic [2:0] PH_LETTER    = 3'd1;
  localparam logic [2:0] PH_INDEX     = 3'd2;
  localparam logic [2:0] PH_VAL_START = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;

  localparam logic [1:0] CV_SKIP   = 2'd0;
  localparam logic [1:0] CV_DIGITS = 2'd1;
  localparam logic [1:0] CV_DONE   = 2'd2;

  typedef struct packed {
    logic [31:0] acc;
    logic [1:0]  ph;
    logic        neg;
  } conv_t;

  localparam conv_t ConvReset = '{acc: 32'd0, ph: CV_SKIP, neg: 1'b0};

  function automatic conv_t conv_feed(conv_t s, qsct_item_t it);
    conv_t r;
    r = s;
    if (s.ph != CV_DONE) begin
      if (it.cls == CLS_DIGIT) begin
        r.acc = {s.acc[28:0], 3'b000} + {s.acc[30:0], 1'b0} + {28'd0, it.data[3:0]};
        r.ph  = CV_DIGITS;
      end else if (s.ph == CV_SKIP && it.cls == CLS_SPACE) begin
        r.ph = CV_SKIP;
      end else if (s.ph == CV_SKIP && (it.cls == CLS_PLUS || it.cls == CLS_MINUS)) begin
        r.neg = (it.cls == CLS_MINUS);
        r.ph  = CV_DIGITS;
      end else begin
        r.ph = CV_DONE;
      end
    end
    return r;
  endfunction

  logic [2:0]      phase_q, phase_n, phase_d;
  logic [CntW-1:0] cnt_q, cnt_n, cnt_d;
  logic [7:0]      letter_q, letter_n, letter_d;
  conv_t           idx_q, idx_n, idx_d;
  conv_t           val_q, val_n, val_d;
  logic            stopped_q, stopped_n, stopped_d;
  logic            emit, str_end, res_valid, res_tok;
  logic [CntW-1:0] cnt_m1;

  logic                 out_valid_q, out_valid_d;
  logic                 out_tok_q;
  logic [7:0]           out_letter_q;
  logic [31:0]          out_index_q;
  logic [31:0]          out_value_q;
  logic                 out_done_q;
  logic [TokenNumW-1:0] out_num_q;

  assign pop_o = item_valid_i && !(out_valid_q && out_stall_i);

  always_comb begin
    phase_n   = phase_q;
    cnt_n     = cnt_q;
    letter_n  = letter_q;
    idx_n     = idx_q;
    val_n     = val_q;
    stopped_n = stopped_q;
    emit      = 1'b0;
    if (item_i.cls != CLS_NUL && !stopped_q) begin
      unique case (phase_q)
        PH_WAIT_Q: begin
          if (item_i.cls == CLS_QMARK) begin
            phase_n = PH_LETTER;
          end
        end
        PH_LETTER: begin
          if (cnt_q >= CntW'(MAX_TOKENS)) begin
            stopped_n = 1'b1;
          end else begin
            cnt_n    = cnt_q + 1'b1;
            letter_n = item_i.data;
            idx_n    = ConvReset;
            val_n    = ConvReset;
            phase_n  = PH_INDEX;
          end
        end
        PH_INDEX: begin
          if (item_i.cls == CLS_EQ) begin
            phase_n = PH_VAL_START;
          end else if (item_i.cls == CLS_AMP) begin
            phase_n = PH_LETTER;
          end else begin
            idx_n = conv_feed(idx_q, item_i);
          end
        end
        PH_VAL_START, PH_VALUE: begin
          if (item_i.cls == CLS_AMP) begin
            emit    = 1'b1;
            phase_n = PH_LETTER;
          end else begin
            val_n   = conv_feed(val_q, item_i);
            phase_n = PH_VALUE;
          end
        end
        default: begin
          phase_n = PH_WAIT_Q;
        end
      endcase
    end

    str_end   = (item_i.cls == CLS_NUL) || item_i.last;
    res_valid = emit || str_end;
    res_tok   = emit || (str_end && !stopped_n && phase_n == PH_VALUE);
    cnt_m1    = cnt_n - 1'b1;

    if (str_end) begin
      phase_d   = PH_WAIT_Q;
      cnt_d     = '0;
      letter_d  = 8'd0;
      idx_d     = ConvReset;
      val_d     = ConvReset;
      stopped_d = 1'b0;
    end else begin
      phase_d   = phase_n;
      cnt_d     = cnt_n;
      letter_d  = letter_n;
      idx_d     = idx_n;
      val_d     = val_n;
      stopped_d = stopped_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_Q;
      cnt_q     <= '0;
      letter_q  <= 8'd0;
      idx_q     <= ConvReset;
      val_q     <= ConvReset;
      stopped_q <= 1'b0;
    end else if (pop_o) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      letter_q  <= letter_d;
      idx_q     <= idx_d;
      val_q     <= val_d;
      stopped_q <= stopped_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      out_tok_q  <= res_tok;
      out_done_q <= str_end;
      if (res_tok) begin
        out_letter_q <= letter_n;
        out_index_q  <= idx_n.neg ? (32'd0 - idx_n.acc) : idx_n.acc;
        out_value_q  <= val_n.neg ? (32'd0 - val_n.acc) : val_n.acc;
        out_num_q    <= TokenNumW'(cnt_m1);
      end else begin
        out_letter_q <= 8'd0;
        out_index_q  <= 32'd0;
        out_value_q  <= 32'd0;
        out_num_q    <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_valid_o  = out_tok_q;
  assign cmd_letter_o   = out_letter_q;
  assign cmd_index_o    = out_index_q;
  assign cmd_value_o    = out_value_q;
  assign string_done_o  = out_done_q;
  assign token_number_o = out_num_q;

endmodule

@@ hw/rtl/query_string_command_tokenizer.sv @@
// Top level of the query string command tokenizer.
// Instantiates qsct_front, qsct_fifo and qsct_back; depends on qsct_pkg.
//
//   channel   direction   handshake                 payload
//   in        input       in_valid_i / in_stall_o   data_byte_i, last_byte_i
//   out       output      out_valid_o / out_stall_i token and string-end fields
//
// One byte is accepted every cycle unless the queue is full; the rate is set by the parser's
// accumulate step, one multiply by ten and add per byte in the back end.
// The byte that causes a result is written into the queue, and the result is then held in the output register.
// Reset is asynchronous and clears all parse state at once.
// Output stalls are absorbed by the output register and a queue of
// QUEUE_DEPTH bytes; the input stalls only when that queue is full.
module query_string_command_tokenizer
  import qsct_pkg::*;
#(
  parameter int MAX_TOKENS  = DefMaxTokens,
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  token_valid_o,
  output logic [7:0]            cmd_letter_o,
  output logic signed [31:0]    cmd_index_o,
  output logic [31:0]           cmd_value_o,
  output logic                  string_done_o,
  output logic [TokenNumW-1:0]  token_number_o
);

  qsct_item_t front_item;
  qsct_item_t queue_item;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;

  qsct_front u_front (
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  qsct_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  assign in_stall_o = queue_full;

  qsct_back #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .pop_o          (queue_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_valid_o  (token_valid_o),
    .cmd_letter_o   (cmd_letter_o),
    .cmd_index_o    (cmd_index_o),
    .cmd_value_o    (cmd_value_o),
    .string_done_o  (string_done_o),
    .token_number_o (token_number_o)
  );

endmodule

@@ hw/rtl/qsct_checker.sv @@
// Port-level checks for the query string command tokenizer.
// Bound to the top level; depends on qsct_pkg for the token number width.
module qsct_checker
  import qsct_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [7:0]            data_byte_i,
  input logic                  last_byte_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  token_valid_o,
  input logic [7:0]            cmd_letter_o,
  input logic signed [31:0]    cmd_index_o,
  input logic [31:0]           cmd_value_o,
  input logic                  string_done_o,
  input logic [TokenNumW-1:0]  token_number_o
);

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i) && $stable(last_byte_i))
    else $error("Stalled input transaction changed.");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result was withdrawn.");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cmd_value_o) && $stable(cmd_index_o))
    else $error("Stalled result payload changed.");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !token_valid_o |-> cmd_letter_o == 8'd0 && cmd_index_o == 32'sd0 &&
      cmd_value_o == 32'd0 && token_number_o == '0)
    else $error("Result without a token carries nonzero fields.");

  a_result_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !string_done_o |-> token_valid_o)
    else $error("Result carries neither a token nor the string end.");

endmodule

bind query_string_command_tokenizer qsct_checker u_qsct_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for query_string_command_tokenizer, the top module is testbench.
// Sends request strings byte by byte, predicts each token and string-end result, and checks them.
// Depends on qsct_pkg and the RTL of the block; it reads no files.
module testbench
  import qsct_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  typedef enum logic [2:0] {
    SEEK_QMARK,
    TAKE_LETTER,
    IN_INDEX,
    VALUE_START,
    IN_VALUE
  } parse_e;

  typedef enum logic [1:0] {
    CONV_SKIP,
    CONV_DIGITS,
    CONV_DONE
  } conv_e;

  typedef struct packed {
    logic                 tok;
    logic [7:0]           letter;
    logic [31:0]          index;
    logic [31:0]          value;
    logic                 done;
    logic [TokenNumW-1:0] number;
  } token_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = 8'h00;
  logic                 last_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 token_valid_o;
  logic [7:0]           cmd_letter_o;
  logic signed [31:0]   cmd_index_o;
  logic [31:0]          cmd_value_o;
  logic                 string_done_o;
  logic [TokenNumW-1:0] token_number_o;

  token_result_t expected_tokens[$];
  logic [7:0]    text_q[$];

  parse_e      pstate;
  int unsigned tokens_begun;
  logic        parse_halted;
  logic [7:0]  letter_q;
  logic [31:0] idx_acc;
  logic [31:0] val_acc;
  conv_e       idx_cv;
  conv_e       val_cv;
  logic        idx_neg;
  logic        val_neg;

  int mismatches = 0;
  int bytes_sent = 0;
  int cycles = 0;
  int send_idle_pct = 32;
  int recv_stall_pct = 67;
  int hold_left = 0;

  query_string_command_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_valid_o  (token_valid_o),
    .cmd_letter_o   (cmd_letter_o),
    .cmd_index_o    (cmd_index_o),
    .cmd_value_o    (cmd_value_o),
    .string_done_o  (string_done_o),
    .token_number_o (token_number_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void atoi_feed(input logic [7:0] c, inout logic [31:0] acc,
                                    inout conv_e cv, inout logic neg);
    if (cv == CONV_DONE) return;
    if (c >= ChZero && c <= ChNine) begin
      acc = acc * 10 + 32'(c - ChZero);
      cv = CONV_DIGITS;
    end else if (cv == CONV_SKIP && (c == ChSpace || (c >= ChTab && c <= ChCr))) begin
    end else if (cv == CONV_SKIP && (c == ChPlus || c == ChMinus)) begin
      neg = (c == ChMinus);
      cv = CONV_DIGITS;
    end else begin
      cv = CONV_DONE;
    end
  endfunction

  function void clear_token_state();
    letter_q = 8'h00;
    idx_acc = '0;
    idx_cv = CONV_SKIP;
    idx_neg = 1'b0;
    val_acc = '0;
    val_cv = CONV_SKIP;
    val_neg = 1'b0;
  endfunction

  function void clear_string_state();
    pstate = SEEK_QMARK;
    tokens_begun = 0;
    parse_halted = 1'b0;
    clear_token_state();
  endfunction

  function token_result_t completed_token();
    token_result_t r;
    r = '0;
    r.tok = 1'b1;
    r.letter = letter_q;
    r.index = idx_neg ? -idx_acc : idx_acc;
    r.value = val_neg ? -val_acc : val_acc;
    r.number = TokenNumW'(tokens_begun - 1);
    return r;
  endfunction

  function void predict_byte(input logic [7:0] c, input logic last);
    token_result_t r;
    logic emit;
    logic ending;
    r = '0;
    emit = 1'b0;
    ending = (c == 8'h00) || last;
    if (c != 8'h00 && !parse_halted) begin
      case (pstate)
        SEEK_QMARK: begin
          if (c == ChQmark) pstate = TAKE_LETTER;
        end
        TAKE_LETTER: begin
          if (tokens_begun >= DefMaxTokens) begin
            parse_halted = 1'b1;
          end else begin
            tokens_begun++;
            clear_token_state();
            letter_q = c;
            pstate = IN_INDEX;
          end
        end
        IN_INDEX: begin
          if (c == ChEq) pstate = VALUE_START;
          else if (c == ChAmp) pstate = TAKE_LETTER;
          else atoi_feed(c, idx_acc, idx_cv, idx_neg);
        end
        VALUE_START, IN_VALUE: begin
          if (c == ChAmp) begin
            r = completed_token();
            emit = 1'b1;
            pstate = TAKE_LETTER;
          end else begin
            atoi_feed(c, val_acc, val_cv, val_neg);
            pstate = IN_VALUE;
          end
        end
        default: pstate = SEEK_QMARK;
      endcase
    end
    if (ending) begin
      if (!emit && !parse_halted && pstate == IN_VALUE) r = completed_token();
      r.done = 1'b1;
      expected_tokens.push_back(r);
      clear_string_state();
    end else if (emit) begin
      expected_tokens.push_back(r);
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Outputs are stable at the falling edge; a transaction seen there completes at the next rise.
  initial begin
    token_result_t e;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $error("result transaction arrived with no expectation pending");
          mismatches++;
        end else begin
          e = expected_tokens.pop_front();
          check_field("token_valid", 32'(e.tok), 32'(token_valid_o));
          check_field("cmd_letter", 32'(e.letter), 32'(cmd_letter_o));
          check_field("cmd_index", e.index, cmd_index_o);
          check_field("cmd_value", e.value, cmd_value_o);
          check_field("string_done", 32'(e.done), 32'(string_done_o));
          check_field("token_number", 32'(e.number), 32'(token_number_o));
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_byte(b, l);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic flush_text(input logic mark_last);
    int i;
    if (text_q.size() == 0) text_q.push_back(8'h00);
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], mark_last && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] space_byte();
    return ($urandom_range(5) == 5) ? ChSpace : 8'(ChTab + $urandom_range(4));
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'(ChZero + $urandom_range(9));
      5: return space_byte();
      6: return $urandom_range(1) ? ChPlus : ChMinus;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic push_number_text();
    int n;
    case ($urandom_range(5))
      0: begin
      end
      1: repeat ($urandom_range(1, 4)) text_q.push_back(text_byte());
      default: begin
        if ($urandom_range(3) == 0) text_q.push_back(space_byte());
        if ($urandom_range(2) == 0) text_q.push_back($urandom_range(1) ? ChPlus : ChMinus);
        n = ($urandom_range(7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
        repeat (n) text_q.push_back(8'(ChZero + $urandom_range(9)));
        if ($urandom_range(4) == 0) text_q.push_back(text_byte());
      end
    endcase
  endtask

  task automatic send_random_string();
    int ntok;
    int t;
    repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(1, 255)));
    if ($urandom_range(19) != 0) text_q.push_back(ChQmark);
    ntok = ($urandom_range(39) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 5);
    for (t = 0; t < ntok; t++) begin
      if ($urandom_range(9) < 7) text_q.push_back(8'($urandom_range(1, 255)));
      else text_q.push_back(8'("a" + $urandom_range(25)));
      if ($urandom_range(1)) push_number_text();
      if ($urandom_range(9) < 8) begin
        text_q.push_back(ChEq);
        push_number_text();
      end
      if (t != ntok - 1) text_q.push_back(ChAmp);
    end
    case ($urandom_range(9))
      6, 7: begin
        text_q.push_back(8'h00);
        flush_text($urandom_range(1));
      end
      8: begin
        text_q.push_back(ChAmp);
        flush_text(1'b1);
      end
      9: begin
        text_q.push_back(ChEq);
        flush_text(1'b1);
      end
      default: flush_text(1'b1);
    endcase
  endtask

  task automatic apply_reset();
    clear_string_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic test_plain_tokens();
    push_text("j?a1=25&b-3= -7");
    flush_text(1'b1);
  endtask

  // Empty value, a token without a value, a trailing equals sign and NUL as string end.
  task automatic test_special_cases();
    push_text("?c=&d7&e=");
    text_q.push_back(8'h00);
    flush_text(1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_field_extremes();
    text_q.push_back(ChQmark);
    text_q.push_back(8'hFF);
    push_text("-2147483648=99999999999&");
    text_q.push_back(8'h80);
    push_text("=-4294967295");
    flush_text(1'b1);
  endtask

  task automatic test_token_limit();
    push_text("?x=9&");
    repeat (31) push_text("a&");
    push_text("z=5");
    flush_text(1'b1);
    push_text("?");
    repeat (31) push_text("a&");
    push_text("b=3");
    flush_text(1'b1);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_bytes);
    int target;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_string();
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls; then the sender
  // waits until every result has come out.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 150;
    push_text("?");
    repeat (12) push_text("k5=123&");
    push_text("z=9");
    flush_text(1'b1);
    wait_drained();
  endtask

  initial begin
    apply_reset();
    test_plain_tokens();
    test_special_cases();
    test_field_extremes();
    test_token_limit();
    test_random_traffic(32, 67, 390);
    test_random_traffic(67, 32, 390);
    test_output_hold();
    test_random_traffic(0, 0, 380);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/qsct_pkg.sv
hw/rtl/qsct_front.sv
hw/rtl/qsct_fifo.sv
hw/rtl/qsct_back.sv
hw/rtl/query_string_command_tokenizer.sv
hw/rtl/qsct_checker.sv
tb/testbench.sv
